[src/gfid_pkg.sv]
`default_nettype none
package gfid_pkg;

    localparam int MaxLength  = 64;
    localparam int SampleBits = 16;
    localparam int CfgBits    = 6;
    localparam int WeightBits = 17;

    typedef struct packed {
        logic signed [SampleBits-1:0] sample;
        logic                         known;
        logic                         last;
    } t_in_beat;

    typedef struct packed {
        logic signed [SampleBits-1:0] value;
        logic [5:0]                   position;
        logic                         was_filled;
        logic                         none_known;
        logic                         last_out;
    } t_out_beat;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear_acc;   // start a new gap: zero sums
        logic rd_en;       // read the memory at rd_addr
        logic acc_en;      // accumulate the registered read as a neighbor
        logic div_start;   // start the divider
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic div_busy;
    } t_dp_sts;

endpackage
`default_nettype wire

[src/gfid_dp.sv]
`default_nettype none
module gfid_dp #(
    parameter int MAX_LENGTH  = gfid_pkg::MaxLength,
    parameter int SAMPLE_BITS = gfid_pkg::SampleBits
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [$clog2(MAX_LENGTH)-1:0]  i_wr_addr,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_wr_data,
    input  wire logic                           i_wr_known,
    input  wire logic [$clog2(MAX_LENGTH)-1:0]  i_rd_addr,
    input  wire logic [$clog2(MAX_LENGTH)-1:0]  i_dist,
    input  wire gfid_pkg::t_dp_cmd              i_cmd,
    output gfid_pkg::t_dp_sts                   o_sts,
    output logic signed [SAMPLE_BITS-1:0]       o_rd_data,
    output logic                                o_rd_known,
    output logic signed [SAMPLE_BITS-1:0]       o_quot
);
    localparam int AW = $clog2(MAX_LENGTH);
    localparam int WB = gfid_pkg::WeightBits;
    localparam int SB = WB + AW + 1;            // weight sum
    localparam int PB = SAMPLE_BITS + WB + 1;   // product
    localparam int NB = PB + AW + 1;            // numerator magnitude-capable
    localparam int DB = NB + 1;                 // 2*mag + wsum
    localparam int CW = $clog2(DB + 1);

    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_LENGTH];
    logic                          r_kmem [MAX_LENGTH];
    logic [AW-1:0]                 r_dist;
    logic [WB-1:0]                 r_w;
    logic                          r_pvalid;
    logic signed [PB-1:0]          r_prod;
    logic [SB-1:0]                 r_wsum;
    logic signed [NB-1:0]          r_num;
    logic                          r_busy;
    logic [CW-1:0]                 r_cnt;
    logic [DB-1:0]                 r_dvd;
    logic [DB:0]                   r_rem;
    logic [SB:0]                   r_den;
    logic                          r_neg;
    logic [DB:0]                   n_rem;
    logic                          q_bit;
    logic [NB-1:0]                 mag;
    logic [WB-1:0]                 w_calc;
    logic [WB-1:0]                 w_tab [MAX_LENGTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr]  <= i_wr_data;
            r_kmem[i_wr_addr] <= i_wr_known;
        end
        if (i_cmd.rd_en) begin
            o_rd_data  <= r_mem[i_rd_addr];
            o_rd_known <= r_kmem[i_rd_addr];
            r_dist     <= i_dist;
        end
    end

    // Weight table, floor(65536 / d) for each distance. Distance zero never
    // reaches the accumulator.
    for (genvar g = 0; g < MAX_LENGTH; g++) begin : g_wtab
        localparam int WeightVal = 65536 / ((g == 0) ? 1 : g);
        assign w_tab[g] = WB'(WeightVal);
    end

    always_comb begin
        w_calc = w_tab[r_dist];
    end

    always_comb begin
        mag   = r_num[NB-1] ? NB'(-r_num) : NB'(r_num);
        n_rem = {r_rem[DB-1:0], r_dvd[DB-1]};
        q_bit = (n_rem >= (DB+1)'(r_den));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_cmd.acc_en;
            if (i_cmd.acc_en) begin
                r_w    <= w_calc;
                r_prod <= PB'($signed({1'b0, w_calc}) * o_rd_data);
            end
            if (i_cmd.clear_acc) begin
                r_wsum <= '0;
                r_num  <= '0;
            end else if (r_pvalid) begin
                r_wsum <= r_wsum + SB'(r_w);
                r_num  <= r_num + NB'(r_prod);
            end
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DB);
                r_neg  <= r_num[NB-1];
                r_dvd  <= DB'({mag, 1'b0}) + DB'(r_wsum);
                r_den  <= {r_wsum, 1'b0};
                r_rem  <= '0;
            end else if (r_busy) begin
                // restoring division, one quotient bit a cycle
                r_dvd <= {r_dvd[DB-2:0], q_bit};
                r_rem <= q_bit ? (n_rem - (DB+1)'(r_den)) : n_rem;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Weighted mean never leaves the sample range, so the low bits suffice.
    always_comb begin
        o_quot = r_neg ? -SAMPLE_BITS'(r_dvd) : SAMPLE_BITS'(r_dvd);
        o_sts.div_busy = r_busy | i_cmd.div_start;
    end
endmodule
`default_nettype wire

[src/gfid_ctrl.sv]
`default_nettype none
module gfid_ctrl #(
    parameter int MAX_LENGTH  = gfid_pkg::MaxLength,
    parameter int SAMPLE_BITS = gfid_pkg::SampleBits
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire gfid_pkg::t_in_beat            i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output gfid_pkg::t_out_beat                o_out,
    input  wire logic [gfid_pkg::CfgBits-1:0]  i_k,
    output logic                               o_wr_en,
    output logic [$clog2(MAX_LENGTH)-1:0]      o_wr_addr,
    output logic [$clog2(MAX_LENGTH)-1:0]      o_rd_addr,
    output logic [$clog2(MAX_LENGTH)-1:0]      o_dist,
    output gfid_pkg::t_dp_cmd                  o_cmd,
    input  wire gfid_pkg::t_dp_sts             i_sts,
    input  wire logic signed [SAMPLE_BITS-1:0] i_rd_data,
    input  wire logic                          i_rd_known,
    input  wire logic signed [SAMPLE_BITS-1:0] i_quot
);
    localparam int AW = $clog2(MAX_LENGTH);
    localparam int CB = $clog2(MAX_LENGTH + 1);
    localparam int KB = gfid_pkg::CfgBits;

    typedef enum logic [3:0] {
        S_LOAD, S_RD, S_CHK, S_LSTEP, S_RSTEP, S_RSTART, S_DRAIN, S_DIV, S_EMIT
    } t_state;

    t_state        r_state;
    logic [CB-1:0] r_cnt;
    logic          r_any;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic [KB-1:0] r_taken;
    logic          r_clear_acc;
    logic          r_div_start;
    logic [KB-1:0] kk;
    logic          wr_ok;
    logic [CB-1:0] lastpos;
    logic          is_gap;
    logic          k_full;
    logic          at_last;
    logic          j_last;
    logic          rd_go;

    // The read address goes to the memory in the same cycle, so the data of
    // a read issued in one state is seen by the next state.
    always_comb begin
        kk      = (i_k == '0) ? KB'(1) : i_k;
        wr_ok   = (r_cnt < CB'(MAX_LENGTH));
        lastpos = r_cnt - CB'(1);
        is_gap  = r_any && !i_rd_known;
        k_full  = i_rd_known && (r_taken + KB'(1) >= kk);
        at_last = (CB'(r_i) + CB'(1) >= r_cnt);
        j_last  = (CB'(r_j) + CB'(1) >= r_cnt);
        o_in_ready = (r_state == S_LOAD);
        o_wr_en    = (r_state == S_LOAD) && i_in_valid && wr_ok;
        o_wr_addr  = AW'(r_cnt);
        rd_go      = 1'b0;
        o_rd_addr  = r_i;
        unique case (r_state)
            S_RD: begin
                rd_go = 1'b1;
            end
            S_CHK: begin
                if (is_gap && (r_i != '0)) begin
                    rd_go     = 1'b1;
                    o_rd_addr = r_i - AW'(1);
                end
            end
            S_LSTEP: begin
                if (!k_full && (r_j != '0)) begin
                    rd_go     = 1'b1;
                    o_rd_addr = r_j - AW'(1);
                end
            end
            S_RSTART: begin
                if (!at_last) begin
                    rd_go     = 1'b1;
                    o_rd_addr = r_i + AW'(1);
                end
            end
            S_RSTEP: begin
                if (!k_full && !j_last) begin
                    rd_go     = 1'b1;
                    o_rd_addr = r_j + AW'(1);
                end
            end
            default: begin
            end
        endcase
        o_dist = (o_rd_addr > r_i) ? (o_rd_addr - r_i) : (r_i - o_rd_addr);
        o_cmd.clear_acc = r_clear_acc;
        o_cmd.rd_en     = rd_go;
        o_cmd.acc_en    = ((r_state == S_LSTEP) || (r_state == S_RSTEP)) && i_rd_known;
        o_cmd.div_start = r_div_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_any       <= 1'b0;
            o_out_valid <= 1'b0;
            r_clear_acc <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_clear_acc <= (r_state == S_CHK) && is_gap;
            // The divider starts in the cycle after the drain state, when the
            // last product has reached the sums.
            r_div_start <= (r_state == S_DRAIN);
            unique case (r_state)
                S_LOAD: begin
                    if (i_in_valid) begin
                        if (wr_ok) begin
                            r_cnt <= r_cnt + CB'(1);
                            r_any <= r_any | i_in.known;
                        end
                        if (i_in.last) begin
                            r_i         <= '0;
                            r_state     <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    o_out.position   <= 6'(r_i);
                    o_out.none_known <= !r_any;
                    o_out.last_out   <= (CB'(r_i) == lastpos);
                    if (!is_gap) begin
                        o_out.value      <= r_any ? i_rd_data : '0;
                        o_out.was_filled <= 1'b0;
                        o_out_valid      <= 1'b1;
                        r_state          <= S_EMIT;
                    end else begin
                        r_taken <= '0;
                        if (r_i == '0) begin
                            r_state <= S_RSTART;
                        end else begin
                            r_j     <= o_rd_addr;
                            r_state <= S_LSTEP;
                        end
                    end
                end
                S_LSTEP: begin
                    if (k_full) begin
                        r_state <= S_RSTART;
                    end else begin
                        if (i_rd_known) r_taken <= r_taken + KB'(1);
                        if (r_j == '0) begin
                            r_state <= S_RSTART;
                        end else begin
                            r_j <= o_rd_addr;
                        end
                    end
                end
                S_RSTART: begin
                    r_taken <= '0;
                    if (at_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_j     <= o_rd_addr;
                        r_state <= S_RSTEP;
                    end
                end
                S_RSTEP: begin
                    if (k_full || j_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        if (i_rd_known) r_taken <= r_taken + KB'(1);
                        r_j <= o_rd_addr;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!i_sts.div_busy) begin
                        o_out.value      <= i_quot;
                        o_out.was_filled <= 1'b1;
                        o_out_valid      <= 1'b1;
                        r_state          <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        if (CB'(r_i) == lastpos) begin
                            r_cnt   <= '0;
                            r_any   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_i     <= r_i + AW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

[src/gap_fill_inverse_distance.sv]
`default_nettype none
// Gap filler by inverse-distance weighting.
// Input beats (sample, known, last) load one per cycle into a sample memory.
// A beat with last set closes the series; beats past MAX_LENGTH are dropped,
// though a dropped beat with last still closes the series.
// The block then emits one output beat per stored sample, in order. Known
// samples pass through. A gap walks its neighbors one memory read a cycle
// (up to the distance to the k-th known sample on each side) and then runs a
// bit-serial restoring divider. The input is not ready during the emit
// phase. When the receiver stalls the output beat is held in its register
// and the controller waits. Reset (synchronous, active low) empties the
// series and sets the neighbor count to 1; a count of 0 acts as 1.
// Configuration is to be written by the user only while idle; the block
// does not enforce this.
module gap_fill_inverse_distance #(
    parameter int MAX_LENGTH  = gfid_pkg::MaxLength,
    parameter int SAMPLE_BITS = gfid_pkg::SampleBits
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire gfid_pkg::t_in_beat            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output gfid_pkg::t_out_beat                o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [gfid_pkg::CfgBits-1:0]  i_cfg_data
);
    localparam int AW = $clog2(MAX_LENGTH);

    logic [gfid_pkg::CfgBits-1:0]  r_k;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 rd_dist;
    gfid_pkg::t_dp_cmd             cmd;
    gfid_pkg::t_dp_sts             sts;
    logic signed [SAMPLE_BITS-1:0] rd_data;
    logic                          rd_known;
    logic signed [SAMPLE_BITS-1:0] quot;
    logic signed [SAMPLE_BITS-1:0] wr_data;

    // The neighbor count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= gfid_pkg::CfgBits'(1);
        end else if (i_cfg_we) begin
            r_k <= i_cfg_data;
        end
    end

    // Unknown samples are stored as zero; they are never used as values.
    assign wr_data = i_in_data.known ? SAMPLE_BITS'(i_in_data.sample) : '0;

    gfid_ctrl #(.MAX_LENGTH(MAX_LENGTH), .SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out_data),
        .i_k(r_k), .o_wr_en(wr_en), .o_wr_addr(wr_addr), .o_rd_addr(rd_addr),
        .o_dist(rd_dist), .o_cmd(cmd), .i_sts(sts), .i_rd_data(rd_data),
        .i_rd_known(rd_known), .i_quot(quot)
    );

    gfid_dp #(.MAX_LENGTH(MAX_LENGTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .i_wr_known(i_in_data.known), .i_rd_addr(rd_addr), .i_dist(rd_dist),
        .i_cmd(cmd), .o_sts(sts), .o_rd_data(rd_data), .o_rd_known(rd_known),
        .o_quot(quot)
    );

    // Loading and emitting never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("load and emit overlap");

    // A result flagged as filled never comes from an all-unknown series.
    a_fill_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.was_filled && o_out_data.none_known))
        else $error("filled beat in empty series");

    // After the final beat is taken, the block loads again.
    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_out) |=> o_in_ready)
        else $error("no return to load");
endmodule
`default_nettype wire
